@@ design/acwr_pkg.sv @@
// Shared types and constants for the azimuth cable-wrap resolver.
package acwr_pkg;

    localparam int AZ_W = 20;

    typedef logic signed [AZ_W-1:0] az_t;

    localparam az_t AZ_MAX = 20'sd524287;
    localparam az_t AZ_MIN = -20'sd524288;

    // Action codes of an input item
    typedef enum logic [1:0] {
        ACT_UNWRAP_NEAR    = 2'd0,
        ACT_UNWRAP_SECTION = 2'd1,
        ACT_CLASSIFY       = 2'd2,
        ACT_PASS           = 2'd3
    } action_t;

    // Wrap section codes
    typedef enum logic [1:0] {
        SEC_NEUTRAL   = 2'd0,
        SEC_CLOCKWISE = 2'd1,
        SEC_COUNTER   = 2'd2,
        SEC_NONE      = 2'd3
    } section_t;

    // Register indexes (byte address 4*index)
    localparam int REG_IDX_W = 3;
    localparam logic [REG_IDX_W-1:0] REG_AXIS_LOW      = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_AXIS_UP       = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_NEUTRAL_LOW   = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_NEUTRAL_UP    = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_CLOCKWISE_LOW = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_CLOCKWISE_UP  = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_COUNTER_LOW   = 3'd6;
    localparam logic [REG_IDX_W-1:0] REG_COUNTER_UP    = 3'd7;

    localparam int PADDR_W = REG_IDX_W + 2;
    localparam int PDATA_W = 32;

    typedef struct packed {
        az_t axis_low;
        az_t axis_up;
        az_t neutral_low;
        az_t neutral_up;
        az_t clockwise_low;
        az_t clockwise_up;
        az_t counter_low;
        az_t counter_up;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        axis_low:      -20'sd49152,
        axis_up:        20'sd49152,
        neutral_low:   -20'sd16384,
        neutral_up:     20'sd16384,
        clockwise_low:  20'sd16384,
        clockwise_up:   20'sd49152,
        counter_low:   -20'sd49152,
        counter_up:    -20'sd16384
    };

    // Input item
    typedef struct packed {
        action_t  action;
        az_t      azimuth_in;
        az_t      previous_azimuth;
        section_t section;
    } cmd_t;

    // Result item
    typedef struct packed {
        az_t      azimuth_out;
        logic     beyond_section;
        section_t wrap_section;
    } res_t;

endpackage

@@ design/azimuth_cable_wrap_resolver_top.sv @@
// Registers: two, the input register and then the result register.
// Throughput: one item per cycle; the input stalls only when the result register is
// held by the consumer and the input register is full.
// Reset: valid bits clear; configuration registers return to their reset limits.
// Datapath: input register, then reduction, classification, turn pick and saturation
// in one combinational pass into the result register.
module azimuth_cable_wrap_resolver_top #(
    parameter int MAX_TURNS      = 3,
    parameter int TURN_FRAC_BITS = 16
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cmd_valid,
    output logic                         cmd_ready,
    input  acwr_pkg::cmd_t               cmd,
    output logic                         res_valid,
    input  logic                         res_ready,
    output acwr_pkg::res_t               res,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [acwr_pkg::PADDR_W-1:0] paddr,
    input  logic [acwr_pkg::PDATA_W-1:0] pwdata,
    output logic [acwr_pkg::PDATA_W-1:0] prdata,
    output logic                         pready
);

    // Internal width: room for the reduced azimuth plus all added turns
    localparam int CW = ((TURN_FRAC_BITS > acwr_pkg::AZ_W) ? TURN_FRAC_BITS : acwr_pkg::AZ_W)
                        + 6;
    localparam logic [CW-1:0] TURN_UNITS = CW'(1) << TURN_FRAC_BITS;
    localparam logic [CW-1:0] TURN_MASK  = TURN_UNITS - CW'(1);
    localparam logic signed [CW-1:0] SAT_MAX = CW'(acwr_pkg::AZ_MAX);
    localparam logic signed [CW-1:0] SAT_MIN = CW'(acwr_pkg::AZ_MIN);

    typedef struct packed {
        acwr_pkg::action_t    action;
        logic signed [CW-1:0] base;
        logic signed [CW-1:0] prev;
        logic signed [CW-1:0] direct;
        logic                 beyond;
        acwr_pkg::section_t   wsec;
    } calc_t;

    acwr_pkg::cfg_t       cfg;
    acwr_pkg::cmd_t       s1_reg;
    logic                 s1_valid_reg;
    calc_t                calc;
    acwr_pkg::res_t       res_reg;
    acwr_pkg::res_t       res_next;
    logic                 res_valid_reg;
    logic                 out_adv;
    logic                 s1_adv;
    logic signed [CW-1:0] az_w;
    logic signed [CW-1:0] axis_low_w;
    logic signed [CW-1:0] axis_up_w;
    logic signed [CW-1:0] sec_lo_w;
    logic signed [CW-1:0] sec_up_w;
    logic [CW-1:0]        axis_off;
    logic [CW-1:0]        sec_off;
    logic signed [CW-1:0] sec_red;
    logic                 sec_none;
    acwr_pkg::section_t   klass;
    logic signed [CW-1:0] best;
    logic signed [CW-1:0] final_val;

    assign pready = 1'b1;

    acwr_regfile u_regfile (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .cfg     (cfg)
    );

    // Flow control: a register loads when the one after it is empty or moving
    assign out_adv   = !res_valid_reg || res_ready;
    assign s1_adv    = !s1_valid_reg || out_adv;
    assign cmd_ready = s1_adv;

    // Reduce into the axis range and into the chosen section, classify
    assign az_w       = CW'(s1_reg.azimuth_in);
    assign axis_low_w = CW'(cfg.axis_low);
    assign axis_up_w  = CW'(cfg.axis_up);

    always_comb
    begin
        sec_none = 1'b0;
        unique case (s1_reg.section)
            acwr_pkg::SEC_NEUTRAL:
            begin
                sec_lo_w = CW'(cfg.neutral_low);
                sec_up_w = CW'(cfg.neutral_up);
            end
            acwr_pkg::SEC_CLOCKWISE:
            begin
                sec_lo_w = CW'(cfg.clockwise_low);
                sec_up_w = CW'(cfg.clockwise_up);
            end
            acwr_pkg::SEC_COUNTER:
            begin
                sec_lo_w = CW'(cfg.counter_low);
                sec_up_w = CW'(cfg.counter_up);
            end
            acwr_pkg::SEC_NONE:
            begin
                sec_lo_w = CW'(cfg.neutral_low);
                sec_up_w = CW'(cfg.neutral_up);
                sec_none = 1'b1;
            end
            default:
            begin
                sec_lo_w = CW'(cfg.neutral_low);
                sec_up_w = CW'(cfg.neutral_up);
                sec_none = 1'b1;
            end
        endcase
    end

    // Turn is a power of two, so the positive remainder is a mask
    assign axis_off = (az_w - axis_low_w) & TURN_MASK;
    assign sec_off  = (az_w - sec_lo_w) & TURN_MASK;
    assign sec_red  = sec_lo_w + $signed(sec_off);

    // Section test order: neutral, clockwise, counter; no match counts as neutral
    always_comb
    begin
        priority if (s1_reg.azimuth_in <= cfg.neutral_up &&
                     s1_reg.azimuth_in >= cfg.neutral_low)
        begin
            klass = acwr_pkg::SEC_NEUTRAL;
        end
        else if (s1_reg.azimuth_in <= cfg.clockwise_up &&
                 s1_reg.azimuth_in >= cfg.clockwise_low)
        begin
            klass = acwr_pkg::SEC_CLOCKWISE;
        end
        else if (s1_reg.azimuth_in <= cfg.counter_up &&
                 s1_reg.azimuth_in >= cfg.counter_low)
        begin
            klass = acwr_pkg::SEC_COUNTER;
        end
        else
        begin
            klass = acwr_pkg::SEC_NEUTRAL;
        end
    end

    always_comb
    begin
        calc.action = s1_reg.action;
        calc.base   = axis_low_w + $signed(axis_off);
        calc.prev   = CW'(s1_reg.previous_azimuth);
        calc.direct = az_w;
        calc.beyond = 1'b0;
        calc.wsec   = acwr_pkg::SEC_NEUTRAL;
        unique case (s1_reg.action)
            acwr_pkg::ACT_UNWRAP_SECTION:
            begin
                if (!sec_none)
                begin
                    calc.direct = sec_red;
                    calc.beyond = (sec_red > sec_up_w);
                end
            end
            acwr_pkg::ACT_CLASSIFY:
            begin
                calc.wsec = klass;
            end
            default:
            begin
                calc.wsec = acwr_pkg::SEC_NEUTRAL;
            end
        endcase
    end

    // Pick the turn for unwrap-near, then saturate
    acwr_pick #(
        .MAX_TURNS      (MAX_TURNS),
        .TURN_FRAC_BITS (TURN_FRAC_BITS),
        .CW             (CW)
    ) u_pick (
        .base    (calc.base),
        .prev    (calc.prev),
        .axis_up (axis_up_w),
        .best    (best)
    );

    assign final_val = (calc.action == acwr_pkg::ACT_UNWRAP_NEAR) ? best : calc.direct;

    always_comb
    begin
        priority if (final_val > SAT_MAX)
        begin
            res_next.azimuth_out = acwr_pkg::AZ_MAX;
        end
        else if (final_val < SAT_MIN)
        begin
            res_next.azimuth_out = acwr_pkg::AZ_MIN;
        end
        else
        begin
            res_next.azimuth_out = final_val[acwr_pkg::AZ_W-1:0];
        end
        res_next.beyond_section = calc.beyond;
        res_next.wrap_section   = calc.wsec;
    end

    // Valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_adv)
            begin
                s1_valid_reg <= cmd_valid;
            end
            if (out_adv)
            begin
                res_valid_reg <= s1_valid_reg;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (s1_adv && cmd_valid)
        begin
            s1_reg <= cmd;
        end
        if (out_adv && s1_valid_reg)
        begin
            res_reg <= res_next;
        end
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

endmodule

@@ design/acwr_regfile.sv @@
// APB-style configuration register file for the cable-wrap limits.
module acwr_regfile (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [acwr_pkg::PADDR_W-1:0] paddr,
    input  logic [acwr_pkg::PDATA_W-1:0] pwdata,
    output logic [acwr_pkg::PDATA_W-1:0] prdata,
    output acwr_pkg::cfg_t               cfg
);

    acwr_pkg::cfg_t                     cfg_reg;
    logic [acwr_pkg::REG_IDX_W-1:0]     idx;
    acwr_pkg::az_t                      wr_val;
    acwr_pkg::az_t                      rd_val;

    assign idx    = paddr[acwr_pkg::PADDR_W-1:2];
    assign wr_val = acwr_pkg::az_t'(pwdata[acwr_pkg::AZ_W-1:0]);

    // Register write on the access cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= acwr_pkg::CFG_RESET;
        end
        else if (psel && penable && pwrite)
        begin
            unique case (idx)
                acwr_pkg::REG_AXIS_LOW:      cfg_reg.axis_low      <= wr_val;
                acwr_pkg::REG_AXIS_UP:       cfg_reg.axis_up       <= wr_val;
                acwr_pkg::REG_NEUTRAL_LOW:   cfg_reg.neutral_low   <= wr_val;
                acwr_pkg::REG_NEUTRAL_UP:    cfg_reg.neutral_up    <= wr_val;
                acwr_pkg::REG_CLOCKWISE_LOW: cfg_reg.clockwise_low <= wr_val;
                acwr_pkg::REG_CLOCKWISE_UP:  cfg_reg.clockwise_up  <= wr_val;
                acwr_pkg::REG_COUNTER_LOW:   cfg_reg.counter_low   <= wr_val;
                acwr_pkg::REG_COUNTER_UP:    cfg_reg.counter_up    <= wr_val;
                default:                     cfg_reg               <= cfg_reg;
            endcase
        end
    end

    // Read mux, sign-extended to the bus width
    always_comb
    begin
        unique case (idx)
            acwr_pkg::REG_AXIS_LOW:      rd_val = cfg_reg.axis_low;
            acwr_pkg::REG_AXIS_UP:       rd_val = cfg_reg.axis_up;
            acwr_pkg::REG_NEUTRAL_LOW:   rd_val = cfg_reg.neutral_low;
            acwr_pkg::REG_NEUTRAL_UP:    rd_val = cfg_reg.neutral_up;
            acwr_pkg::REG_CLOCKWISE_LOW: rd_val = cfg_reg.clockwise_low;
            acwr_pkg::REG_CLOCKWISE_UP:  rd_val = cfg_reg.clockwise_up;
            acwr_pkg::REG_COUNTER_LOW:   rd_val = cfg_reg.counter_low;
            acwr_pkg::REG_COUNTER_UP:    rd_val = cfg_reg.counter_up;
            default:                     rd_val = cfg_reg.axis_low;
        endcase
    end

    assign prdata = acwr_pkg::PDATA_W'(rd_val);
    assign cfg    = cfg_reg;

endmodule

@@ design/acwr_pick.sv @@
// Turn candidate selection: picks the whole-turn offset nearest the reference.
module acwr_pick #(
    parameter int MAX_TURNS      = 3,
    parameter int TURN_FRAC_BITS = 16,
    parameter int CW             = 26
) (
    input  logic signed [CW-1:0] base,
    input  logic signed [CW-1:0] prev,
    input  logic signed [CW-1:0] axis_up,
    output logic signed [CW-1:0] best
);

    logic signed [CW-1:0] cand [MAX_TURNS+1];
    logic signed [CW-1:0] cand_gap [MAX_TURNS+1];

    // All candidates and their distances in parallel
    for (genvar i = 0; i <= MAX_TURNS; i++)
    begin : g_cand
        localparam logic signed [CW-1:0] OFFSET = CW'(i) << TURN_FRAC_BITS;
        logic signed [CW-1:0] diff;

        assign cand[i]     = base + OFFSET;
        assign diff        = cand[i] - prev;
        assign cand_gap[i] = diff[CW-1] ? -diff : diff;
    end

    // Walk up while the next turn is allowed and no farther away; ties go up
    always_comb
    begin
        logic go;
        go   = 1'b1;
        best = base;
        for (int i = 1; i <= MAX_TURNS; i++)
        begin
            if (go && (cand[i] <= axis_up) && (cand_gap[i-1] >= cand_gap[i]))
            begin
                best = cand[i];
            end
            else
            begin
                go = 1'b0;
            end
        end
    end

endmodule
